[rtl/rjc_pkg.sv]
// shared constants and types for the lidar range-jump clustering core
// no dependencies; imported by every module of the block
package rjc_pkg;

  localparam int MAX_POINTS = 2048;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int LBL_W      = IDX_W + 1;
  localparam int RANGE_W    = 16;

  localparam logic [RANGE_W-1:0] THRESH_RESET = RANGE_W'(300);
  localparam logic [LBL_W-1:0]   LABEL_MAX    = LBL_W'(MAX_POINTS);
  localparam logic [IDX_W-1:0]   INDEX_LAST   = IDX_W'(MAX_POINTS - 1);

  localparam logic KIND_POINT   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic               range_invalid;
    logic               scan_end;
  } sample_t;

  typedef struct packed {
    logic             record_kind;
    logic [LBL_W-1:0] point_label;
    logic [IDX_W-1:0] tail_start_index;
    logic             wrap_merge;
    logic [LBL_W-1:0] cluster_count;
    logic             last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    rec0;
    result_t    rec1;
  } push_t;

endpackage

[rtl/rjc_label.sv]
// per-sample labeling logic and scan state of the clustering core
// depends on rjc_pkg; produces one or two result records per beat
module rjc_label
  import rjc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  sample_t            in_sample,
  input  logic [RANGE_W-1:0] threshold,
  input  logic               space_ok,
  output logic               fire,
  output push_t              push
);

  logic [RANGE_W-1:0] previous_range;
  logic               previous_valid;
  logic [RANGE_W-1:0] first_range;
  logic               first_valid;
  logic [LBL_W-1:0]   cluster_counter;
  logic [IDX_W-1:0]   sample_index;
  logic [IDX_W-1:0]   tail_run_start;
  logic [LBL_W-1:0]   previous_label;

  logic               valid;
  logic               is_first;
  logic [RANGE_W-1:0] diff_prev;
  logic [RANGE_W-1:0] diff_first;
  logic [RANGE_W-1:0] first_range_eff;
  logic               first_valid_eff;
  logic               bump;
  logic [LBL_W-1:0]   counter_next;
  logic [LBL_W-1:0]   label;
  logic [IDX_W-1:0]   tail_next;
  logic               merge;

  assign fire     = in_valid && space_ok;
  assign valid    = !in_sample.range_invalid;
  assign is_first = (sample_index == '0);

  assign diff_prev = (in_sample.range_mm >= previous_range) ?
                     in_sample.range_mm - previous_range :
                     previous_range - in_sample.range_mm;

  assign first_range_eff = is_first ? in_sample.range_mm : first_range;
  assign first_valid_eff = is_first ? valid : first_valid;

  assign diff_first = (in_sample.range_mm >= first_range_eff) ?
                      in_sample.range_mm - first_range_eff :
                      first_range_eff - in_sample.range_mm;

  assign bump = valid && !is_first && (!previous_valid || diff_prev > threshold) &&
                (cluster_counter < LABEL_MAX);
  assign counter_next = cluster_counter + LBL_W'(bump);
  assign label        = valid ? counter_next : '0;

  always_comb begin
    if (is_first) begin
      tail_next = '0;
    end else if (label != previous_label) begin
      tail_next = sample_index;
    end else begin
      tail_next = tail_run_start;
    end
  end

  assign merge = valid && first_valid_eff && (diff_first <= threshold);

  always_comb begin
    push.num                   = fire ? (in_sample.scan_end ? 2'd2 : 2'd1) : 2'd0;
    push.rec0.record_kind      = KIND_POINT;
    push.rec0.point_label      = label;
    push.rec0.tail_start_index = '0;
    push.rec0.wrap_merge       = 1'b0;
    push.rec0.cluster_count    = '0;
    push.rec0.last_of_run      = !in_sample.scan_end;
    push.rec1.record_kind      = KIND_SUMMARY;
    push.rec1.point_label      = '0;
    push.rec1.tail_start_index = tail_next;
    push.rec1.wrap_merge       = merge;
    push.rec1.cluster_count    = counter_next;
    push.rec1.last_of_run      = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_range  <= '0;
      previous_valid  <= 1'b0;
      first_range     <= '0;
      first_valid     <= 1'b0;
      cluster_counter <= LBL_W'(1);
      sample_index    <= '0;
      tail_run_start  <= '0;
      previous_label  <= '0;
    end else if (fire) begin
      if (in_sample.scan_end) begin
        previous_range  <= '0;
        previous_valid  <= 1'b0;
        first_range     <= '0;
        first_valid     <= 1'b0;
        cluster_counter <= LBL_W'(1);
        sample_index    <= '0;
        tail_run_start  <= '0;
        previous_label  <= '0;
      end else begin
        previous_range  <= in_sample.range_mm;
        previous_valid  <= valid;
        first_range     <= first_range_eff;
        first_valid     <= first_valid_eff;
        cluster_counter <= counter_next;
        tail_run_start  <= tail_next;
        previous_label  <= label;
        if (sample_index != INDEX_LAST) begin
          sample_index <= sample_index + IDX_W'(1);
        end
      end
    end
  end

  a_counter_range: assert property (@(posedge clk) disable iff (rst)
    cluster_counter != '0 && cluster_counter <= LABEL_MAX)
    else $error("cluster counter out of range");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    fire && in_sample.scan_end |=> sample_index == '0 && cluster_counter == LBL_W'(1))
    else $error("scan state not cleared after scan end");

  a_counter_monotonic: assert property (@(posedge clk) disable iff (rst)
    fire && !in_sample.scan_end |=> cluster_counter >= $past(cluster_counter))
    else $error("cluster counter decreased within a scan");

endmodule

[rtl/rjc_out_fifo.sv]
// four-entry result queue taking up to two records per cycle
// depends on rjc_pkg; drives the output stream of the core
module rjc_out_fifo
  import rjc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  input  logic    pop,
  output logic    out_valid,
  output result_t out_head,
  output logic    space_ok
);

  localparam logic [FIFO_AW:0] LEVEL_OK = (FIFO_AW + 1)'(FIFO_DEPTH - 2);

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic [FIFO_AW:0]   count_next;

  assign out_valid  = (count != '0);
  assign out_head   = mem[rd_ptr];
  assign space_ok   = (count <= LEVEL_OK);
  assign count_next = count + (FIFO_AW + 1)'(push.num) - (FIFO_AW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr] <= push.rec0;
    end
    if (push.num == 2'd2) begin
      mem[wr_ptr + FIFO_AW'(1)] <= push.rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push.num);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.num != 2'd0 |-> space_ok)
    else $error("push into full result queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> out_valid)
    else $error("pop from empty result queue");

  a_level: assert property (@(posedge clk) disable iff (rst)
    count <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("result queue level out of range");

endmodule

[rtl/lidar_scan_range_jump_clustering_core.sv]
// top level of the lidar range-jump clustering core
// depends on rjc_pkg, rjc_label and rjc_out_fifo
//
// usage:
//   s_* stream carries one range sample per beat: tdata is the range in mm,
//   tuser flags an invalid sample, tlast marks the final sample of a scan.
//   m_* stream carries result beats: one point record per sample, and after
//   the final sample of a scan a summary record (tuser high) as well.
//   m_tlast is high on the last result beat belonging to one input sample.
//   cfg_we / cfg_wdata write the jump threshold; write only while idle.
// timing:
//   a sample waits in the input register and is labeled and queued when it
//   leaves it, so its first result beat is offered from the result queue;
//   a full queue can hold the sample in the input register before that.
//   one sample is accepted per cycle while the queue has room; the rate is
//   set by the single output port, so a scan of n samples needs n + 1 output beats.
// reset: scan state clears, threshold returns to 300 mm, queue empties.
// stall: a four-entry result queue holds records while m_tready is low; the
//   input register fills and s_tready drops once under two entries are free.
module lidar_scan_range_jump_clustering_core
  import rjc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [15:0]        s_tdata,    // range_mm
  input  logic               s_tuser,    // range_invalid
  input  logic               s_tlast,    // scan_end
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [39:0]        m_tdata,    // point_label, tail_start_index, wrap_merge,
                                         // cluster_count, zero pad
  output logic               m_tuser,    // record_kind
  output logic               m_tlast,    // last_of_run
  input  logic               cfg_we,
  input  logic [RANGE_W-1:0] cfg_wdata
);

  logic [RANGE_W-1:0] threshold;
  logic               in_valid;
  sample_t            in_sample;
  logic               fire;
  logic               space_ok;
  push_t              push;
  result_t            head;

  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample.range_mm      <= s_tdata;
      in_sample.range_invalid <= s_tuser;
      in_sample.scan_end      <= s_tlast;
    end
  end

  rjc_label u_label (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_sample (in_sample),
    .threshold (threshold),
    .space_ok  (space_ok),
    .fire      (fire),
    .push      (push)
  );

  rjc_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (m_tvalid && m_tready),
    .out_valid (m_tvalid),
    .out_head  (head),
    .space_ok  (space_ok)
  );

  assign m_tdata = {4'b0, head.cluster_count, head.wrap_merge,
                    head.tail_start_index, head.point_label};
  assign m_tuser = head.record_kind;
  assign m_tlast = head.last_of_run;

endmodule
